// ===== hw/rtl/hsec_pkg.sv =====
package hsec_pkg;

  localparam int WORD_W = 63;  // codeword / data word width
  localparam int POS_W  = 6;   // position / syndrome width
  localparam int R_W    = 3;   // parity count width
  localparam int LEN_W  = 7;   // n + r before clamping

  localparam logic [POS_W-1:0] DATA_BITS_RST = POS_W'(4);

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] word_in;
  } hsec_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] codeword_out;
    logic [POS_W-1:0]  error_position;
    logic [R_W-1:0]    parity_bit_count;
  } hsec_out_t;

  // derived code geometry for the current data length
  typedef struct packed {
    logic [POS_W-1:0] n;
    logic [R_W-1:0]   r;
    logic [POS_W-1:0] len;
  } hsec_cfg_t;

  // positions (bit p-1 holds position p) whose index has bit j set
  function automatic logic [WORD_W-1:0] pos_sel(input int j);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      m[p-1] = ((p >> j) & 1) == 1;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/hamming_sec_encode_syndrome.sv =====
// Channel  Ports                         Dir  Handshake
// input    start, busy, in_item          in   taken when start && !busy
// result   out_valid, out_item           out  one-cycle strobe, no backpressure
// config   cfg_we, cfg_wdata             in   written when cfg_we
//
// One word per clock, sustained. The input register captures the word, the
// encode / syndrome XOR trees run, the result register presents it on
// out_item with out_valid for one cycle.
// busy is held low; the pipeline never fills since the result side cannot stall.
// Reset (rst_n low, synchronous) clears both valid bits and sets data_bits to 4.
module hamming_sec_encode_syndrome #(
  parameter int MAX_DATA_BITS   = 57,  // 1..57, clamp for data_bits
  parameter int MAX_PARITY_BITS = 6    // 2..6, cap on parity count
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input word
  input  logic                       start,
  output logic                       busy,
  input  hsec_pkg::hsec_in_t         in_item,
  // result word
  output logic                       out_valid,
  output hsec_pkg::hsec_out_t        out_item,
  // data length register
  input  logic                       cfg_we,
  input  logic [hsec_pkg::POS_W-1:0] cfg_wdata
);
  import hsec_pkg::*;

  logic       in_vld_r;
  hsec_in_t   in_item_r;
  logic       out_vld_r;
  hsec_out_t  out_item_r;
  hsec_out_t  res_nxt;
  hsec_cfg_t  geom;

  // never stalls: a word can enter every cycle
  assign busy = 1'b0;

  hsec_cfg #(
    .MAX_DATA_BITS   (MAX_DATA_BITS),
    .MAX_PARITY_BITS (MAX_PARITY_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item_r <= in_item;
    end
  end

  // encode / syndrome between the two registers
  hsec_core u_core (
    .item (in_item_r),
    .geom (geom),
    .res  (res_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/hsec_cfg.sv =====
module hsec_cfg #(
  parameter int MAX_DATA_BITS   = 57,
  parameter int MAX_PARITY_BITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hsec_pkg::POS_W-1:0] cfg_wdata,
  output hsec_pkg::hsec_cfg_t        geom
);
  import hsec_pkg::*;

  logic [POS_W-1:0] data_bits_r;
  logic [POS_W-1:0] n_eff;
  logic [R_W-1:0]   r_eff;
  logic [LEN_W-1:0] len_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= DATA_BITS_RST;
    end else if (cfg_we) begin
      data_bits_r <= cfg_wdata;
    end
  end

  // clamp n into 1..MAX_DATA_BITS
  always_comb begin
    n_eff = data_bits_r;
    if (n_eff > POS_W'(MAX_DATA_BITS)) n_eff = POS_W'(MAX_DATA_BITS);
    if (n_eff == '0) n_eff = POS_W'(1);
  end

  // least r with 2^r >= n+r+1; 2^r - r is increasing so compares are independent
  always_comb begin
    r_eff = R_W'(MAX_PARITY_BITS);
    for (int k = MAX_PARITY_BITS - 1; k >= 1; k--) begin
      if ((LEN_W'(1) << k) >= LEN_W'(n_eff) + LEN_W'(k) + LEN_W'(1)) begin
        r_eff = R_W'(k);
      end
    end
  end

  assign len_sum = LEN_W'(n_eff) + LEN_W'(r_eff);

  always_comb begin
    geom.n   = n_eff;
    geom.r   = r_eff;
    geom.len = (len_sum > LEN_W'(WORD_W)) ? POS_W'(WORD_W) : len_sum[POS_W-1:0];
  end

endmodule

// ===== hw/rtl/hsec_core.sv =====
module hsec_core (
  input  hsec_pkg::hsec_in_t  item,
  input  hsec_pkg::hsec_cfg_t geom,
  output hsec_pkg::hsec_out_t res
);
  import hsec_pkg::*;

  logic [WORD_W-1:0] data_mask;
  logic [WORD_W-1:0] pos_mask;
  logic [WORD_W-1:0] data_in;
  logic [WORD_W-1:0] placed;
  logic [WORD_W-1:0] src;
  logic [POS_W-1:0]  syn;
  logic [WORD_W-1:0] code;

  assign data_mask = ~({WORD_W{1'b1}} << geom.n);
  assign pos_mask  = ~({WORD_W{1'b1}} << geom.len);
  assign data_in   = item.word_in & data_mask;

  // scatter data bits onto non-power-of-two positions
  for (genvar p = 1; p <= WORD_W; p++) begin : g_place
    if ((p & (p - 1)) == 0) begin : g_par
      assign placed[p-1] = 1'b0;
    end else begin : g_dat
      localparam int DIDX = p - 1 - $clog2(p + 1);
      assign placed[p-1] = data_in[DIDX];
    end
  end

  // one XOR tree per syndrome bit, shared by both modes
  assign src = ((item.func == FUNC_CHECK) ? item.word_in : placed) & pos_mask;

  always_comb begin
    for (int j = 0; j < POS_W; j++) begin
      syn[j] = ^(src & pos_sel(j));
    end
  end

  always_comb begin
    code = src;
    for (int j = 0; j < POS_W; j++) begin
      if ((R_W'(j) < geom.r) && (POS_W'(1 << j) <= geom.len)) begin
        code[(1 << j) - 1] = syn[j];
      end
    end
  end

  always_comb begin
    res.parity_bit_count = geom.r;
    if (item.func == FUNC_CHECK) begin
      res.codeword_out   = '0;
      res.error_position = syn;
    end else begin
      res.codeword_out   = code;
      res.error_position = '0;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import hsec_pkg::*;

  localparam int MAX_N       = 57;   // data length clamp
  localparam int MAX_R       = 6;    // parity count cap
  localparam int LATENCY     = 2;    // input reg + result reg
  localparam int HALF_PERIOD = 5;
  localparam int GAP_MAX     = 18;   // longest sender pause per word
  localparam int QUIET_LIMIT = 400;  // cycles with no word moving before we give up
  localparam int PHASES      = 14;   // random phases, one data length each
  localparam int PHASE_WORDS = 75;
  localparam int DIR_ROWS    = 31;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam hsec_in_t  NO_WORD = '0;
  localparam hsec_out_t NO_WANT = '0;

  // one row of the directed plan: either a data length write or a word,
  // with the result typed in where it is obvious
  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] data_bits;
    hsec_in_t         word;
    logic             typed;
    hsec_out_t        want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [DIR_ROWS] = '{
    // reset length n=4: r=3, codeword is positions 1..7
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h0},   1'b1, '{63'h0,  6'd0, 3'd3}},
    '{1'b0, 6'd0, '{FUNC_ENCODE, ALL_ONES}, 1'b1, '{63'h7F, 6'd0, 3'd3}},  // upper bits ignored
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h1},   1'b1, '{63'h07, 6'd0, 3'd3}},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h5},   1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h0},   1'b1, '{63'h0,  6'd0, 3'd3}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h1},   1'b1, '{63'h0,  6'd1, 3'd3}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h40},  1'b1, '{63'h0,  6'd7, 3'd3}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h80},  1'b1, '{63'h0,  6'd0, 3'd3}},  // past codeword
    '{1'b0, 6'd0, '{FUNC_CHECK,  ALL_ONES}, 1'b1, '{63'h0,  6'd0, 3'd3}},
    // zero length reads as one data bit: r=2
    '{1'b1, 6'd0, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h1},   1'b1, '{63'h7,  6'd0, 3'd2}},
    '{1'b0, 6'd0, '{FUNC_ENCODE, ALL_ONES}, 1'b1, '{63'h7,  6'd0, 3'd2}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h4},   1'b1, '{63'h0,  6'd3, 3'd2}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h7},   1'b1, '{63'h0,  6'd0, 3'd2}},
    // full length: r=6, codeword fills all 63 bits
    '{1'b1, 6'd57, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, ALL_ONES}, 1'b1, '{ALL_ONES, 6'd0, 3'd6}},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h0},   1'b1, '{63'h0,  6'd0, 3'd6}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h4000_0000_0000_0000}, 1'b1, '{63'h0, 6'd63, 3'd6}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  ALL_ONES}, 1'b1, '{63'h0,  6'd0, 3'd6}},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h2AAA_5555_1234_ABCD}, 1'b0, NO_WANT},
    // above the max clamps to 57
    '{1'b1, 6'd63, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, ALL_ONES}, 1'b1, '{ALL_ONES, 6'd0, 3'd6}},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h1},   1'b1, '{63'h0,  6'd1, 3'd6}},
    // n=5, len 9: double error gives a syndrome beyond the codeword
    '{1'b1, 6'd5, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'hC0},  1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h1F},  1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_CHECK,  63'h100}, 1'b0, NO_WANT},
    '{1'b1, 6'd1, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h1},   1'b1, '{63'h7,  6'd0, 3'd2}},
    '{1'b1, 6'd26, NO_WORD, 1'b0, NO_WANT},
    '{1'b0, 6'd0, '{FUNC_ENCODE, 63'h3FF_FFFF}, 1'b0, NO_WANT}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  hsec_in_t         in_item;
  logic             out_valid;
  hsec_out_t        out_item;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  // testbench copy of the data length register
  logic [POS_W-1:0] data_bits_shadow = DATA_BITS_RST;
  hsec_out_t        pending_results[$];   // expected result words, oldest first

  int errors       = 0;
  int quiet_cycles = 0;
  int n_encode     = 0;
  int n_check      = 0;
  int n_flip1      = 0;
  int n_flip2      = 0;
  int n_lengths    = 0;

  always #HALF_PERIOD clk = ~clk;

  hamming_sec_encode_syndrome #(
    .MAX_DATA_BITS  (MAX_N),
    .MAX_PARITY_BITS(MAX_R)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // n after clamping, r = least r with 2^r >= n+r+1, codeword length n+r
  function automatic hsec_cfg_t code_geometry(input logic [POS_W-1:0] v);
    hsec_cfg_t g;
    int n;
    int r;
    n = int'(v);
    if (n > MAX_N) n = MAX_N;
    if (n < 1) n = 1;
    r = 1;
    while (r < MAX_R && (1 << r) < n + r + 1) r++;
    g.n   = POS_W'(n);
    g.r   = R_W'(r);
    g.len = POS_W'((n + r > WORD_W) ? WORD_W : n + r);
    return g;
  endfunction

  // expected result word for one input word under a given data length
  function automatic hsec_out_t predict_hamming(input logic [POS_W-1:0] v, input hsec_in_t w);
    hsec_cfg_t        g;
    hsec_out_t        res;
    logic [POS_W-1:0] syn;
    int               d;
    g   = code_geometry(v);
    res = '0;
    syn = '0;
    d   = 0;
    if (w.func == FUNC_ENCODE) begin
      // data bits go LSB first to the non power of two positions
      for (int p = 1; p <= int'(g.len); p++) begin
        if ((p & (p - 1)) != 0) begin
          if (d < int'(g.n) && w.word_in[d]) begin
            res.codeword_out[p-1] = 1'b1;
            syn ^= POS_W'(p);
          end
          d++;
        end
      end
      // parity at 2^j is bit j of the XOR of set data positions
      for (int j = 0; j < int'(g.r); j++) begin
        if ((1 << j) <= int'(g.len) && syn[j]) res.codeword_out[(1 << j) - 1] = 1'b1;
      end
    end else begin
      // syndrome over the whole codeword; bits past len do not count
      for (int p = 1; p <= int'(g.len); p++) begin
        if (w.word_in[p-1]) syn ^= POS_W'(p);
      end
      res.error_position = syn;
    end
    res.parity_bit_count = g.r;
    return res;
  endfunction

  // present one word after an optional pause; start stays high on return so a
  // back-to-back word needs no extra edge
  task automatic send_word(input hsec_in_t w, input logic typed, input hsec_out_t want,
                           input int gap);
    hsec_out_t exp_res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    exp_res = typed ? want : predict_hamming(data_bits_shadow, w);
    pending_results.push_back(exp_res);
    if (w.func == FUNC_ENCODE) n_encode++;
    else n_check++;
  endtask

  // length writes only with the pipe drained
  task automatic write_data_bits(input logic [POS_W-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    data_bits_shadow = v;
    n_lengths++;
  endtask

  // result side: every strobe must match the oldest expected word
  always @(posedge clk) begin
    hsec_out_t exp_res;
    if (out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_item);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.codeword_out !== exp_res.codeword_out) begin
          $display("%0t: codeword_out expected %h actual %h", $time,
                   exp_res.codeword_out, out_item.codeword_out);
          errors++;
        end
        if (out_item.error_position !== exp_res.error_position) begin
          $display("%0t: error_position expected %0d actual %0d", $time,
                   exp_res.error_position, out_item.error_position);
          errors++;
        end
        if (out_item.parity_bit_count !== exp_res.parity_bit_count) begin
          $display("%0t: parity_bit_count expected %0d actual %0d", $time,
                   exp_res.parity_bit_count, out_item.parity_bit_count);
          errors++;
        end
      end
    end
  end

  // watchdog: no word moving in either direction for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: stalled, %0d result words outstanding", $time, pending_results.size());
      $display("hamming_sec_encode_syndrome regression: fail");
      $finish;
    end
  end

  initial begin
    hsec_in_t         w;
    hsec_cfg_t        g;
    logic [POS_W-1:0] v;
    logic [63:0]      raw;
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] len_mask;
    int               kind;
    int               p1;
    int               p2;
    int               gap;
    bit               burst;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].load) write_data_bits(DIRECTED[i].data_bits);
      else send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want,
                     $urandom_range(0, GAP_MAX));
    end

    // random phases: extremes first, then arbitrary register values
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       v = '0;
        1:       v = POS_W'(MAX_N);
        2:       v = '1;
        3:       v = POS_W'(1);
        4:       v = POS_W'(MAX_N + 1);
        default: v = POS_W'($urandom_range(0, 63));
      endcase
      write_data_bits(v);
      g        = code_geometry(v);
      len_mask = (int'(g.len) >= WORD_W) ? ALL_ONES : ((63'h1 << g.len) - 63'h1);
      burst    = ($urandom_range(0, 3) == 0);  // some phases run with no pauses

      for (int k = 0; k < PHASE_WORDS; k++) begin
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        w.word_in = raw[WORD_W-1:0];
        if ($urandom_range(0, 1) == 0) begin
          w.func = FUNC_ENCODE;
          // mostly clean data, some with junk above bit n
          if (kind < 6) w.word_in &= (63'h1 << g.n) - 63'h1;
        end else begin
          w.func = FUNC_CHECK;
          cw = predict_hamming(v, '{FUNC_ENCODE, raw[WORD_W-1:0]}).codeword_out;
          p1 = $urandom_range(1, int'(g.len));
          p2 = $urandom_range(1, int'(g.len));
          if (p2 == p1) p2 = (p1 % int'(g.len)) + 1;
          if (kind < 3) begin
            w.word_in = cw;                                       // clean codeword
          end else if (kind < 6) begin
            w.word_in = cw ^ (63'h1 << (p1 - 1));                 // single bit error
            n_flip1++;
          end else if (kind < 8) begin
            w.word_in = cw ^ (63'h1 << (p1 - 1)) ^ (63'h1 << (p2 - 1));  // double error
            n_flip2++;
          end else if (kind == 8) begin
            w.word_in = (cw ^ (63'h1 << (p1 - 1))) | (raw[WORD_W-1:0] & ~len_mask);
            n_flip1++;                                            // junk above codeword
          end
          // kind 9: raw noise
        end
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        send_word(w, 1'b0, NO_WANT, gap);
      end
    end

    // drain and let the pipe settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d encode and %0d check words over %0d data length writes",
             n_encode, n_check, n_lengths);
    $display("check words with single errors: %0d, with double errors: %0d", n_flip1, n_flip2);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("hamming_sec_encode_syndrome regression: pass");
    end else begin
      $display("hamming_sec_encode_syndrome regression: fail");
    end
    $finish;
  end

endmodule
